@@ hdl/cdu_pkg.sv @@
`default_nettype none

package cdu_pkg;

    // token and lane geometry
    localparam int TOK_W          = 11;
    localparam int MAX_LANES      = 9;
    localparam int NUM_CB_DEFAULT = 9;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_TOKEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_TOKEN   = 2'd1;

    localparam logic [TOK_W-1:0] START_TOKEN_RST = 11'd1025;
    localparam logic [TOK_W-1:0] END_TOKEN_RST   = 11'd1024;

    // output queue depth (room for two frames behind the head)
    localparam int Q_DEPTH = 4;

    // one aligned frame
    typedef struct packed {
        logic [MAX_LANES-1:0][TOK_W-1:0] tok;
        logic                            last;
    } frame_t;

    // frames written into the output queue this cycle
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

`default_nettype wire

@@ hdl/codebook_delay_undo.sv @@
`default_nettype none
// A frame enters the output queue when its step is accepted; out_valid offers
// the head frame. Throughput: one step per cycle while in_stall is low; a final
// step of a long sequence pushes two frames into the four-entry output queue.
// in_stall rises while fewer than two queue entries are free.
// Reset: step count cleared, tokens to their reset values, queue emptied;
// the skew lines are not cleared (a frame only reads taps filled in its sequence).

module codebook_delay_undo #(
    parameter int CB_COUNT = cdu_pkg::NUM_CB_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [cdu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cdu_pkg::TOK_W-1:0]     cfg_data,
    // step input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_0,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_1,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_2,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_3,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_4,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_5,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_6,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_7,
    input  wire logic [cdu_pkg::TOK_W-1:0]     step_tok_8,
    input  wire logic                          final_step,
    // frame output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_0,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_1,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_2,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_3,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_4,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_5,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_6,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_7,
    output logic      [cdu_pkg::TOK_W-1:0]     frame_tok_8,
    output logic                               final_frame
);
    import cdu_pkg::*;

    localparam int CNT_W = $clog2(CB_COUNT + 1);

    logic [TOK_W-1:0]                start_token_reg, end_token_reg;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [MAX_LANES-1:0][TOK_W-1:0] in_tok;
    logic                            accept, full, shift_en, room_low;
    push_t                           push;
    frame_t                          frame_a, frame_b, out_frame;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_token_reg <= START_TOKEN_RST;
            end_token_reg   <= END_TOKEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_TOKEN: start_token_reg <= cfg_data;
                REG_END_TOKEN:   end_token_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // step handshake and sequence count
    assign in_stall = room_low;
    assign accept   = in_valid && !in_stall;
    assign full     = cnt_reg == CNT_W'(CB_COUNT);
    assign shift_en = accept && !final_step;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (final_step)
            begin
                cnt_next = '0;
            end
            else if (!full)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign in_tok = {step_tok_8, step_tok_7, step_tok_6, step_tok_5, step_tok_4,
                     step_tok_3, step_tok_2, step_tok_1, step_tok_0};

    // one skew lane per codebook; lane k is CB_COUNT-k deep
    generate
        for (genvar k = 0; k < MAX_LANES; k++)
        begin : g_lane
            if (k < CB_COUNT)
            begin : g_used
                cdu_lane #(
                    .DEPTH(CB_COUNT - k)
                ) u_lane (
                    .clk        (clk),
                    .shift_en   (shift_en),
                    .tok_in     (in_tok[k]),
                    .start_token(start_token_reg),
                    .end_token  (end_token_reg),
                    .tok_a      (frame_a.tok[k]),
                    .tok_b      (frame_b.tok[k])
                );
            end
            else
            begin : g_unused
                assign frame_a.tok[k] = end_token_reg;
                assign frame_b.tok[k] = end_token_reg;
            end
        end
    endgenerate

    assign frame_a.last = 1'b0;
    assign frame_b.last = 1'b1;

    // frames due from this step
    assign push.first  = accept && full;
    assign push.second = accept && full && final_step;

    cdu_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .frame_a  (frame_a),
        .frame_b  (frame_b),
        .room_low (room_low),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_frame(out_frame)
    );

    assign frame_tok_0 = out_frame.tok[0];
    assign frame_tok_1 = out_frame.tok[1];
    assign frame_tok_2 = out_frame.tok[2];
    assign frame_tok_3 = out_frame.tok[3];
    assign frame_tok_4 = out_frame.tok[4];
    assign frame_tok_5 = out_frame.tok[5];
    assign frame_tok_6 = out_frame.tok[6];
    assign frame_tok_7 = out_frame.tok[7];
    assign frame_tok_8 = out_frame.tok[8];
    assign final_frame = out_frame.last;

`ifndef SYNTHESIS
    a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CB_COUNT))
        else $error("step count beyond codebook count");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_step |=> cnt_reg == '0)
        else $error("count not cleared after final step");

    a_cnt_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !final_step && !full |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("count did not advance on a filling step");
`endif

endmodule

`default_nettype wire

@@ hdl/cdu_lane.sv @@
`default_nettype none

module cdu_lane #(
    parameter int DEPTH = 1
) (
    input  wire logic                     clk,
    input  wire logic                     shift_en,
    input  wire logic [cdu_pkg::TOK_W-1:0] tok_in,
    input  wire logic [cdu_pkg::TOK_W-1:0] start_token,
    input  wire logic [cdu_pkg::TOK_W-1:0] end_token,
    output logic      [cdu_pkg::TOK_W-1:0] tok_a,
    output logic      [cdu_pkg::TOK_W-1:0] tok_b
);
    import cdu_pkg::*;

    logic [TOK_W-1:0] line_reg  [DEPTH];
    logic [TOK_W-1:0] line_next [DEPTH];

    // begin-of-stream and pad tokens both leave as the end token
    function automatic logic [TOK_W-1:0] fix_tok(
        input logic [TOK_W-1:0] tok,
        input logic [TOK_W-1:0] st,
        input logic [TOK_W-1:0] et
    );
        fix_tok = (tok == st || tok == et) ? et : tok;
    endfunction

    // skew line: newest token at tap 0
    always_comb
    begin
        line_next[0] = tok_in;
        for (int d = 1; d < DEPTH; d++)
        begin
            line_next[d] = line_reg[d-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            line_reg <= line_next;
        end
    end

    // oldest tap feeds the regular frame
    assign tok_a = fix_tok(line_reg[DEPTH-1], start_token, end_token);

    // the closing frame is one step younger; the last lane takes it live
    generate
        if (DEPTH == 1)
        begin : g_live
            assign tok_b = fix_tok(tok_in, start_token, end_token);
        end
        else
        begin : g_tap
            assign tok_b = fix_tok(line_reg[DEPTH-2], start_token, end_token);
        end
    endgenerate

endmodule

`default_nettype wire

@@ hdl/cdu_outq.sv @@
`default_nettype none

module cdu_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cdu_pkg::push_t  push,
    input  wire cdu_pkg::frame_t frame_a,
    input  wire cdu_pkg::frame_t frame_b,
    output logic                 room_low,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output cdu_pkg::frame_t      out_frame
);
    import cdu_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    frame_t           q_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_push;
    logic             pop;

    // merge: up to two frames in, one out per transaction
    assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
    end

    // frame storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            q_reg[wr_ptr_reg] <= frame_a;
        end
        if (push.second)
        begin
            q_reg[wr_ptr_p1] <= frame_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // keep room for a two-frame step
    assign room_low  = cnt_reg > CNT_W'(Q_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_frame = q_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(Q_DEPTH))
        else $error("output queue count overflow");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("closing frame pushed without regular frame");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> cnt_reg <= CNT_W'(Q_DEPTH - 2))
        else $error("frame pushed without room for two");
`endif

endmodule

`default_nettype wire

@@ verif/tb_codebook_delay_undo.sv @@
`timescale 1ns / 1ps

module tb_codebook_delay_undo;

    import cdu_pkg::*;

    localparam int NCB = NUM_CB_DEFAULT;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef logic [MAX_LANES-1:0][TOK_W-1:0] lanes_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TOK_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    lanes_t step_tok;
    logic final_step;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TOK_W-1:0] frame_tok_0, frame_tok_1, frame_tok_2, frame_tok_3, frame_tok_4;
    logic [TOK_W-1:0] frame_tok_5, frame_tok_6, frame_tok_7, frame_tok_8;
    logic final_frame;

    // predictor state
    logic [TOK_W-1:0] start_tok;
    logic [TOK_W-1:0] end_tok;
    int unsigned steps_taken;
    logic [TOK_W-1:0] skew_lines [MAX_LANES][MAX_LANES];
    frame_t frames_due [$];

    int unsigned errors = 0;
    bit steady = 1'b0;

    codebook_delay_undo dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .step_tok_0  (step_tok[0]),
        .step_tok_1  (step_tok[1]),
        .step_tok_2  (step_tok[2]),
        .step_tok_3  (step_tok[3]),
        .step_tok_4  (step_tok[4]),
        .step_tok_5  (step_tok[5]),
        .step_tok_6  (step_tok[6]),
        .step_tok_7  (step_tok[7]),
        .step_tok_8  (step_tok[8]),
        .final_step  (final_step),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_tok_0 (frame_tok_0),
        .frame_tok_1 (frame_tok_1),
        .frame_tok_2 (frame_tok_2),
        .frame_tok_3 (frame_tok_3),
        .frame_tok_4 (frame_tok_4),
        .frame_tok_5 (frame_tok_5),
        .frame_tok_6 (frame_tok_6),
        .frame_tok_7 (frame_tok_7),
        .frame_tok_8 (frame_tok_8),
        .final_frame (final_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // start and end markers both come out as the end token
    function automatic logic [TOK_W-1:0] clean_tok(input logic [TOK_W-1:0] tok);
        if (tok == start_tok || tok == end_tok)
            return end_tok;
        return tok;
    endfunction

    // frames caused by one accepted step, then the skew lines advance unless the step is final
    task automatic undelay_predict(input lanes_t toks, input logic fin);
        frame_t fr;
        bit full;
        full = (steps_taken >= NCB);
        if (full)
        begin
            for (int k = 0; k < MAX_LANES; k++)
                fr.tok[k] = end_tok;
            for (int k = 0; k < NCB; k++)
                fr.tok[k] = clean_tok(skew_lines[k][NCB-k-1]);
            fr.last = 1'b0;
            frames_due.insert(frames_due.size(), fr);
            if (fin)
            begin
                for (int k = 0; k < MAX_LANES; k++)
                    fr.tok[k] = end_tok;
                for (int k = 0; k < NCB - 1; k++)
                    fr.tok[k] = clean_tok(skew_lines[k][NCB-k-2]);
                fr.tok[NCB-1] = clean_tok(toks[NCB-1]);
                fr.last = 1'b1;
                frames_due.insert(frames_due.size(), fr);
            end
        end
        if (fin)
            steps_taken = 0;
        else
        begin
            for (int k = 0; k < NCB; k++)
            begin
                for (int d = NCB - k - 1; d > 0; d--)
                    skew_lines[k][d] = skew_lines[k][d-1];
                skew_lines[k][0] = toks[k];
            end
            if (!full)
                steps_taken++;
        end
    endtask

    // one step transaction, with random gaps ahead of it unless steady is set
    task automatic send_step(input lanes_t toks, input logic fin);
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        step_tok   <= toks;
        final_step <= fin;
        do
            @(posedge clk);
        while (in_stall);
        undelay_predict(toks, fin);
    endtask

    // stop sending, let every frame out, then give the pipeline time to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_TOKEN: start_tok = val;
            REG_END_TOKEN:   end_tok = val;
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // biased towards the marker tokens and the range ends
    function automatic logic [TOK_W-1:0] pick_tok();
        int unsigned r;
        r = $urandom_range(15);
        case (r)
            0, 1:    return start_tok;
            2, 3:    return end_tok;
            4:       return '0;
            5:       return '1;
            default: return TOK_W'($urandom_range(2047));
        endcase
    endfunction

    task automatic run_sequence(input int unsigned len);
        lanes_t toks;
        for (int unsigned s = 0; s < len; s++)
        begin
            for (int k = 0; k < MAX_LANES; k++)
                toks[k] = pick_tok();
            send_step(toks, s == len - 1);
        end
    endtask

    // sequences of one and of nine steps leave no frame
    task automatic test_short_sequences();
        run_sequence(1);
        run_sequence(NCB);
        settle();
    endtask

    // shortest long sequence: the final step gives the regular and the closing frame
    task automatic test_shortest_long_sequence();
        lanes_t toks;
        logic [TOK_W-1:0] pattern [6];
        pattern = '{'0, '1, start_tok, end_tok, 11'h555, 11'h2AA};
        for (int s = 0; s <= NCB; s++)
        begin
            for (int k = 0; k < MAX_LANES; k++)
                toks[k] = pattern[(s + k) % 6];
            if (s == NCB)
                toks[NCB-1] = start_tok;
            send_step(toks, s == NCB);
        end
        settle();
    endtask

    // random sequences under a range of register settings
    task automatic test_random_traffic();
        int unsigned done;
        int unsigned len;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_START_TOKEN, START_TOKEN_RST);
                    write_reg(REG_END_TOKEN, END_TOKEN_RST);
                end
                1:
                begin
                    write_reg(REG_START_TOKEN, '0);
                    write_reg(REG_END_TOKEN, '1);
                end
                2:
                begin
                    write_reg(REG_START_TOKEN, '1);
                    write_reg(REG_END_TOKEN, '0);
                end
                3:
                begin
                    // both markers the same value
                    write_reg(REG_START_TOKEN, 11'd700);
                    write_reg(REG_END_TOKEN, 11'd700);
                end
                4:
                begin
                    // a write to an unused index changes nothing
                    write_reg(REG_SPARE, TOK_W'($urandom_range(2047)));
                end
                default:
                begin
                    write_reg(REG_START_TOKEN, TOK_W'($urandom_range(2047)));
                    write_reg(REG_END_TOKEN, TOK_W'($urandom_range(2047)));
                end
            endcase
            steady = (p == 5);
            done = 0;
            while (done < 125)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(1, NCB);
                else
                    len = $urandom_range(NCB + 1, 40);
                run_sequence(len);
                done += len;
            end
            settle();
            steady = 1'b0;
        end
    endtask

    // frame checker and receiver stall
    always @(posedge clk)
    begin
        frame_t seen;
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.tok = {frame_tok_8, frame_tok_7, frame_tok_6, frame_tok_5, frame_tok_4,
                        frame_tok_3, frame_tok_2, frame_tok_1, frame_tok_0};
            seen.last = final_frame;
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame transaction");
                errors++;
            end
            else
            begin
                want = frames_due.pop_front();
                for (int k = 0; k < MAX_LANES; k++)
                    if (seen.tok[k] !== want.tok[k])
                    begin
                        $error("frame_tok_%0d: expected %0d, got %0d",
                               k, want.tok[k], seen.tok[k]);
                        errors++;
                    end
                if (seen.last !== want.last)
                begin
                    $error("final_frame: expected %0d, got %0d", want.last, seen.last);
                    errors++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < 18);
    end

    // hard limit on the run
    initial
    begin
        #10_000_000;
        $display("codebook_delay_undo: mismatch");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_START_TOKEN;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        step_tok   <= '0;
        final_step <= 1'b0;
        start_tok   = START_TOKEN_RST;
        end_tok     = END_TOKEN_RST;
        steps_taken = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_sequences();
        test_shortest_long_sequence();
        test_random_traffic();

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0 && frames_due.size() == 0)
            $display("codebook_delay_undo: match");
        else
            $display("codebook_delay_undo: mismatch");
        $finish;
    end

endmodule
